>>> hw/rtl/sird_pkg.sv
`default_nettype none

package sird_pkg;

    localparam int VALUE_BITS    = 32;
    localparam int RADIX_W       = 4;
    localparam int DIGIT_W       = 4;
    localparam int CHAR_W        = 7;

    // quotient bits resolved per divider cycle
    localparam int BITS_PER_CYC  = 8;
    localparam int DIV_CYCLES    = (VALUE_BITS + BITS_PER_CYC - 1) / BITS_PER_CYC;
    localparam int MAG_W         = DIV_CYCLES * BITS_PER_CYC;
    localparam int DIV_CNT_W     = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

    localparam int MAX_DIGITS    = VALUE_BITS;
    localparam int DCNT_W        = $clog2(MAX_DIGITS + 1);
    localparam int STACK_W       = MAX_DIGITS * DIGIT_W;

    localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(10);
    localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = CHAR_W'(48);
    localparam logic [CHAR_W-1:0] CHAR_NINE  = CHAR_W'(57);
    localparam logic [CHAR_W-1:0] CHAR_MINUS = CHAR_W'(45);

endpackage

`default_nettype wire

>>> hw/rtl/signed_integer_to_radix_digits.sv
// Signed integer to ASCII text in radix 2..10.
//
// Input channel: i_valid / o_ready carry one signed value per transaction.
// Output channel: o_valid / i_ready carry one character per transaction,
// '-' first for a negative value, then the digits most significant first;
// o_last_char marks the final character. Zero gives the single digit '0'.
// Configuration: i_cfg_wr_en writes i_cfg_wr_data as the radix at once;
// codes below 2 act as 2, codes above 10 act as 10. Write only when idle.
//
// The digits come from one shared restoring divider that resolves eight
// quotient bits per cycle; the digits are stacked and then popped one per
// cycle into the output register while the receiver accepts them.
// An item is taken, divided one digit after another and then emitted,
// sign first; a stalled receiver makes it take longer.
// o_ready is high only while no item is in flight; the last character may
// still wait in the output register while the next item is taken.
// A stalled receiver holds the character in place and halts the pop.
// Reset (synchronous, active low) clears the sequencer and output valid,
// and sets the radix to 10.
`default_nettype none

module signed_integer_to_radix_digits
    import sird_pkg::*;
(
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_cfg_wr_en,
    input  wire        [RADIX_W-1:0]      i_cfg_wr_data,
    input  wire                           i_valid,
    output logic                          o_ready,
    input  wire  signed [VALUE_BITS-1:0]  i_value,
    output logic                          o_valid,
    input  wire                           i_ready,
    output logic       [CHAR_W-1:0]       o_char_code,
    output logic                          o_last_char
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_SIGN,
        S_EMIT
    } t_state;

    t_state                r_state, n_state;
    logic [RADIX_W-1:0]    r_radix, n_radix;
    logic                  r_neg, n_neg;
    logic [MAG_W-1:0]      r_mag, n_mag;
    logic [DIGIT_W-1:0]    r_rem, n_rem;
    logic [DIV_CNT_W-1:0]  r_divcnt, n_divcnt;
    logic [DCNT_W-1:0]     r_cnt, n_cnt;
    logic [STACK_W-1:0]    r_stack, n_stack;
    logic                  r_o_valid, n_o_valid;
    logic [CHAR_W-1:0]     r_char, n_char;
    logic                  r_last, n_last;

    logic [MAG_W-1:0]      div_mag;
    logic [DIGIT_W-1:0]    div_rem;
    logic [VALUE_BITS-1:0] in_mag;
    logic                  out_load;

    // shared divider: BITS_PER_CYC restoring steps on a narrow remainder
    always_comb begin
        logic [DIGIT_W:0]        t;
        logic [DIGIT_W-1:0]      rem;
        logic [BITS_PER_CYC-1:0] chunk;
        logic [BITS_PER_CYC-1:0] qb;
        rem   = r_rem;
        chunk = r_mag[MAG_W-1 -: BITS_PER_CYC];
        qb    = '0;
        for (int i = BITS_PER_CYC - 1; i >= 0; i--) begin
            t = {rem, chunk[i]};
            if (t >= {1'b0, r_radix}) begin
                t     = t - {1'b0, r_radix};
                qb[i] = 1'b1;
            end
            rem = t[DIGIT_W-1:0];
        end
        div_rem = rem;
        if (MAG_W > BITS_PER_CYC) begin
            div_mag = {r_mag[MAG_W-BITS_PER_CYC-1:0], qb};
        end else begin
            div_mag = MAG_W'(qb);
        end
    end

    // magnitude without sign, so the most negative value survives
    assign in_mag   = i_value[VALUE_BITS-1] ? (~i_value + 1'b1) : i_value;
    assign out_load = !r_o_valid || i_ready;

    always_comb begin
        n_state   = r_state;
        n_radix   = r_radix;
        n_neg     = r_neg;
        n_mag     = r_mag;
        n_rem     = r_rem;
        n_divcnt  = r_divcnt;
        n_cnt     = r_cnt;
        n_stack   = r_stack;
        n_o_valid = r_o_valid && !i_ready;
        n_char    = r_char;
        n_last    = r_last;

        if (i_cfg_wr_en) begin
            if (i_cfg_wr_data < RADIX_MIN) begin
                n_radix = RADIX_MIN;
            end else if (i_cfg_wr_data > RADIX_MAX) begin
                n_radix = RADIX_MAX;
            end else begin
                n_radix = i_cfg_wr_data;
            end
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_neg    = i_value[VALUE_BITS-1];
                    n_mag    = MAG_W'(in_mag);
                    n_rem    = '0;
                    n_divcnt = '0;
                    n_cnt    = '0;
                    n_state  = S_DIV;
                end
            end
            S_DIV: begin
                n_mag    = div_mag;
                n_rem    = div_rem;
                n_divcnt = r_divcnt + 1'b1;
                if (r_divcnt == DIV_CNT_W'(DIV_CYCLES - 1)) begin
                    // digit complete: push it, least significant first
                    n_stack  = {r_stack[STACK_W-DIGIT_W-1:0], div_rem};
                    n_cnt    = r_cnt + 1'b1;
                    n_rem    = '0;
                    n_divcnt = '0;
                    if (div_mag == '0) begin
                        n_state = r_neg ? S_SIGN : S_EMIT;
                    end
                end
            end
            S_SIGN: begin
                if (out_load) begin
                    n_o_valid = 1'b1;
                    n_char    = CHAR_MINUS;
                    n_last    = 1'b0;
                    n_state   = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_load) begin
                    n_o_valid = 1'b1;
                    n_char    = CHAR_ZERO + CHAR_W'(r_stack[DIGIT_W-1:0]);
                    n_last    = (r_cnt == DCNT_W'(1));
                    n_stack   = r_stack >> DIGIT_W;
                    n_cnt     = r_cnt - 1'b1;
                    if (r_cnt == DCNT_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_radix   <= RADIX_RESET;
            r_divcnt  <= '0;
            r_cnt     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_radix   <= n_radix;
            r_divcnt  <= n_divcnt;
            r_cnt     <= n_cnt;
            r_o_valid <= n_o_valid;
        end
        r_neg   <= n_neg;
        r_mag   <= n_mag;
        r_rem   <= n_rem;
        r_stack <= n_stack;
        r_char  <= n_char;
        r_last  <= n_last;
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_valid     = r_o_valid;
    assign o_char_code = r_char;
    assign o_last_char = r_last;

    a_radix_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_radix >= RADIX_MIN) && (r_radix <= RADIX_MAX))
        else $error("radix register out of range");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("ready still high after input transaction");

    a_emit_has_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_cnt != '0))
        else $error("emitting with an empty digit stack");

    a_rem_below_radix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_radix))
        else $error("partial remainder not below radix");

    a_char_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_char_code == CHAR_MINUS && !o_last_char) ||
                     (o_char_code >= CHAR_ZERO && o_char_code <= CHAR_NINE)))
        else $error("illegal character on output");

endmodule

`default_nettype wire

>>> tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sird_pkg::*;

    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 4000;
    localparam int TAIL_CYCLES = 200;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 37;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } char_t;

    typedef struct {
        bit                    wr;
        logic [RADIX_W-1:0]    radix;
        logic [VALUE_BITS-1:0] value;
        string                 text;
    } row_t;

    logic                          i_clk         = 1'b0;
    logic                          i_rst_n       = 1'b0;
    logic                          i_cfg_wr_en   = 1'b0;
    logic        [RADIX_W-1:0]     i_cfg_wr_data = '0;
    logic                          i_valid       = 1'b0;
    logic signed [VALUE_BITS-1:0]  i_value       = '0;
    logic                          i_ready       = 1'b0;
    logic                          o_ready;
    logic                          o_valid;
    logic        [CHAR_W-1:0]      o_char_code;
    logic                          o_last_char;

    char_t              pending_chars[$];
    logic [RADIX_W-1:0] radix_now     = RADIX_RESET;
    int                 mismatch_count = 0;
    int                 quiet_cycles   = 0;
    bit                 hold_req       = 1'b0;
    bit                 tx_gaps_on     = 1'b0;
    bit                 rx_gaps_on     = 1'b0;

    signed_integer_to_radix_digits dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_char_code   (o_char_code),
        .o_last_char   (o_last_char)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_count < 50) begin
            $display("MISMATCH @%0t: %s", $realtime, msg);
        end
        mismatch_count++;
    endtask

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // expected text of one value in the current radix, sign first, MSD first
    function automatic void predict_digits(input logic [VALUE_BITS-1:0] v);
        logic [VALUE_BITS-1:0] mag;
        logic [VALUE_BITS-1:0] base;
        logic [DIGIT_W-1:0]    digs[$];
        if (radix_now < RADIX_MIN) begin
            base = VALUE_BITS'(RADIX_MIN);
        end else if (radix_now > RADIX_MAX) begin
            base = VALUE_BITS'(RADIX_MAX);
        end else begin
            base = VALUE_BITS'(radix_now);
        end
        // unsigned negate, so the most negative value keeps its magnitude
        mag = v[VALUE_BITS-1] ? (~v + 1'b1) : v;
        do begin
            digs.push_front(DIGIT_W'(mag % base));
            mag = mag / base;
        end while (mag != '0);
        if (v[VALUE_BITS-1]) begin
            pending_chars.push_back('{code: CHAR_MINUS, last: 1'b0});
        end
        foreach (digs[k]) begin
            pending_chars.push_back('{code: CHAR_ZERO + CHAR_W'(digs[k]),
                                      last: (k == digs.size() - 1)});
        end
    endfunction

    function automatic logic [VALUE_BITS-1:0] rand_value();
        int                    r;
        logic [VALUE_BITS-1:0] v;
        r = $urandom_range(0, 9);
        if (r < 6) begin
            v = $urandom;
        end else if (r < 8) begin
            v = $urandom >> $urandom_range(1, 31);
            if ($urandom_range(0, 1) == 1) v = -v;
        end else if (r == 8) begin
            v = $urandom_range(0, 12);
            if ($urandom_range(0, 1) == 1) v = -v;
        end else begin
            case ($urandom_range(0, 3))
                0: v = 32'h8000_0000;
                1: v = 32'h7FFF_FFFF;
                2: v = 32'hFFFF_FFFF;
                default: v = '0;
            endcase
        end
        return v;
    endfunction

    // text empty: expectation comes from the predictor
    task automatic offer_value(input logic [VALUE_BITS-1:0] v, input string text);
        int g;
        int r;
        g = 0;
        if (tx_gaps_on) begin
            r = $urandom_range(0, 99);
            if (r >= 93) g = $urandom_range(10, 40);
            else if (r >= 60) g = $urandom_range(1, 3);
        end
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= v;
        do @(posedge i_clk); while (!o_ready);
        if (text.len() == 0) begin
            predict_digits(v);
        end else begin
            for (int k = 0; k < text.len(); k++) begin
                pending_chars.push_back('{code: CHAR_W'(text[k]),
                                          last: (k == text.len() - 1)});
            end
        end
    endtask

    task automatic wait_text_done();
        i_valid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_radix(input logic [RADIX_W-1:0] r);
        wait_text_done();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= r;
        @(posedge i_clk);
        radix_now = r;
        i_cfg_wr_en <= 1'b0;
    endtask

    // receiver side: random back-pressure plus one long hold on request
    initial begin
        forever begin
            if (hold_req) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (rx_gaps_on && $urandom_range(0, 2) == 0) begin
                i_ready <= 1'b0;
                repeat (idle_len()) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        char_t want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_chars.size() == 0) begin
                report_mismatch($sformatf("character %0d with no transaction pending",
                                          o_char_code));
            end else begin
                want = pending_chars.pop_front();
                if (o_char_code !== want.code) begin
                    report_mismatch($sformatf("char_code %0d, expected %0d",
                                              o_char_code, want.code));
                end
                if (o_last_char !== want.last) begin
                    report_mismatch($sformatf("last_char %0b, expected %0b",
                                              o_last_char, want.last));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("signed_integer_to_radix_digits verification failed");
            $finish;
        end
    end

    initial begin
        row_t rows[$];
        rows.push_back('{1'b0, RADIX_W'(0),  32'd0,          "0"});
        rows.push_back('{1'b0, RADIX_W'(0),  32'h7FFF_FFFF,  "2147483647"});
        rows.push_back('{1'b0, RADIX_W'(0),  32'h8000_0000,  "-2147483648"});
        rows.push_back('{1'b0, RADIX_W'(0),  32'hFFFF_FFFF,  "-1"});
        rows.push_back('{1'b0, RADIX_W'(0),  32'd9,          "9"});
        rows.push_back('{1'b0, RADIX_W'(0),  32'd10,         "10"});
        rows.push_back('{1'b1, RADIX_W'(2),  32'h7FFF_FFFF,
                         "1111111111111111111111111111111"});
        rows.push_back('{1'b0, RADIX_W'(0),  32'h8000_0000,
                         "-10000000000000000000000000000000"});
        rows.push_back('{1'b0, RADIX_W'(0),  32'd5,          "101"});
        rows.push_back('{1'b0, RADIX_W'(0),  32'hFFFF_FFFF,  "-1"});
        // codes 0 and 1 fall back to binary
        rows.push_back('{1'b1, RADIX_W'(0),  32'd6,          "110"});
        rows.push_back('{1'b1, RADIX_W'(1),  32'd3,          "11"});
        rows.push_back('{1'b0, RADIX_W'(0),  32'd0,          "0"});
        // codes above ten fall back to decimal
        rows.push_back('{1'b1, RADIX_W'(15), 32'd123,        "123"});
        rows.push_back('{1'b0, RADIX_W'(0),  32'hFFFF_FFD3,  "-45"});
        rows.push_back('{1'b1, RADIX_W'(11), 32'd99,         "99"});
        rows.push_back('{1'b1, RADIX_W'(8),  32'h7FFF_FFFF,  "17777777777"});
        rows.push_back('{1'b0, RADIX_W'(0),  32'h8000_0000,  "-20000000000"});
        rows.push_back('{1'b1, RADIX_W'(3),  32'hDEAD_BEEF,  ""});
        rows.push_back('{1'b1, RADIX_W'(5),  32'h1234_5678,  ""});
        rows.push_back('{1'b1, RADIX_W'(7),  32'hFFFF_0001,  ""});
        rows.push_back('{1'b1, RADIX_W'(9),  32'd1_000_000,  ""});
        rows.push_back('{1'b1, RADIX_W'(4),  32'h5555_5555,  ""});
        rows.push_back('{1'b1, RADIX_W'(6),  32'hAAAA_AAAA,  ""});
        rows.push_back('{1'b1, RADIX_W'(10), 32'hFFFF_FF9C,  "-100"});

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            if (rows[i].wr) write_radix(rows[i].radix);
            offer_value(rows[i].value, rows[i].text);
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            write_radix(RADIX_W'($urandom_range(0, 15)));
            // first phase runs flat out on both sides
            tx_gaps_on = (ph != 0) && ($urandom_range(0, 3) != 0);
            rx_gaps_on = (ph != 0) && ($urandom_range(0, 3) != 0);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 2 && n == 10) hold_req = 1'b1;
                if (ph == 5 && n == 18) wait_text_done();
                offer_value(rand_value(), "");
            end
        end

        wait_text_done();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("signed_integer_to_radix_digits verification clean");
        end else begin
            $display("signed_integer_to_radix_digits verification failed");
        end
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/sird_pkg.sv
hw/rtl/signed_integer_to_radix_digits.sv
tb/tb_top.sv
